>>> src/assert_macros.svh
// Assertion macros used by the RTL file atp_div.
// Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> src/atp_pkg.sv
// Types and constants of the activation tile partition block.
// No dependencies.
package atp_pkg;
    localparam int unsigned TILE_W = 13;
    localparam int unsigned ELEM_W = 32;
    localparam int unsigned CPG_W  = 16;
    localparam int unsigned BIDX_W = 16;
    localparam int unsigned BTOT_W = 17;

    localparam logic [1:0] REGION_LOW  = 2'd0;
    localparam logic [1:0] REGION_MID  = 2'd1;
    localparam logic [1:0] REGION_HIGH = 2'd2;

    typedef struct packed {
        logic [ELEM_W-1:0] elems;
        logic              batched;
        logic [CPG_W-1:0]  cpg;
        logic [BIDX_W-1:0] bidx;
        logic [BTOT_W-1:0] btot;
        logic [TILE_W-1:0] tidx;
        logic [TILE_W-1:0] tiles;
        logic              bad;
        logic [BTOT_W-1:0] per;
        logic [TILE_W-1:0] run;
        logic [TILE_W-1:0] first;
        logic [CPG_W-1:0]  cpge;
        logic              zero;
        logic [ELEM_W-1:0] groups;
        logic [ELEM_W-1:0] total;
        logic [1:0]        region;
    } t_side;
endpackage

>>> src/atp_in_if.sv
// Query channel: valid/ready handshake with the query fields.
// No dependencies.
interface atp_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] element_count;
    logic        batched_mode;
    logic [15:0] channels_per_group;
    logic [15:0] batch_index;
    logic [16:0] batch_total;
    logic [12:0] tile_index;
    modport source (output valid, element_count, batched_mode, channels_per_group,
                    batch_index, batch_total, tile_index, input ready);
    modport sink (input valid, element_count, batched_mode, channels_per_group,
                  batch_index, batch_total, tile_index, output ready);
endinterface

>>> src/atp_out_if.sv
// Result channel: valid/ready handshake with the boundary result.
// No dependencies.
interface atp_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] boundary_offset;
    logic        bad_request;
    modport source (output valid, boundary_offset, bad_request, input ready);
    modport sink (input valid, boundary_offset, bad_request, output ready);
endinterface

>>> src/activation_tile_partition_core.sv
// Top level of the activation tile partition block: boundary query pipeline.
// Depends on atp_pkg, atp_in_if, atp_out_if and atp_div.
//
//   channel  direction  transaction
//   i_in     in         one boundary query (element count, mode, indexes)
//   o_out    out        boundary offset and bad request flag
//   cfg      in         tile count write (i_cfg_we, i_cfg_data)
//
// One query enters per cycle unless the output stalls; the path runs through the chain of eight
// bit-serial divider pipelines (one quotient bit per stage) and the output stage.
// Reset is synchronous, active low, clears all valid bits and sets tile count to 1024.
// A stall at the output fills empty stages upstream first, then holds i_in.ready low.
module activation_tile_partition_core
    import atp_pkg::*;
#(
    parameter int unsigned MAX_TILES = 4096
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [TILE_W-1:0] i_cfg_data,
    atp_in_if.sink           i_in,
    atp_out_if.source        o_out
);
    localparam int unsigned SW = $bits(t_side);

    logic [TILE_W-1:0] r_tile_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile_count <= TILE_W'(1024);
        end else if (i_cfg_we) begin
            r_tile_count <= i_cfg_data;
        end
    end

    // stage handshakes
    logic v1, v2, v3, v4, v5, v6, v7, v8;
    logic rd1, rd2, rd3, rd4, rd5, rd6, rd7, rd8, rd_out;
    t_side s0, s1, s2, s3, s4, s5, s6, s7, s8;
    t_side n1, n2, n3, n4, n5, n6, n7, n8;
    logic [16:0] q1, q2;
    logic [12:0] r1;
    logic [16:0] r2;
    logic [12:0] q3, r3;
    logic [15:0] q4;
    logic [16:0] r4;
    logic [31:0] q5;
    logic [15:0] r5;
    logic [31:0] q6;
    logic [12:0] r6;
    logic [31:0] q7, r7;
    logic [44:0] q8;
    logic [12:0] r8;
    logic [31:0] d7_den;
    logic [12:0] d8_den;
    logic [44:0] d8_num;
    logic [TILE_W-1:0] w_tiles;
    logic [31:0] w_maxper;
    logic [12:0] w_use;
    logic [12:0] w_i;
    logic [13:0] w_end;

    always_comb begin
        if (r_tile_count == '0) begin
            w_tiles = TILE_W'(1);
        end else if (int'(r_tile_count) > int'(MAX_TILES)) begin
            w_tiles = TILE_W'(MAX_TILES);
        end else begin
            w_tiles = r_tile_count;
        end
        s0         = '0;
        s0.elems   = i_in.element_count;
        s0.batched = i_in.batched_mode;
        s0.cpg     = i_in.channels_per_group;
        s0.bidx    = i_in.batch_index;
        s0.btot    = i_in.batch_total;
        s0.tidx    = i_in.tile_index;
        s0.tiles   = w_tiles;
        s0.bad     = (i_in.tile_index > w_tiles) || ({1'b0, i_in.batch_index} >= i_in.batch_total);
    end

    atp_div #(.NW(17), .DW(13), .SW(SW)) u_div1 (
        .i_clk, .i_rst_n, .i_valid(i_in.valid), .o_ready(i_in.ready),
        .i_num(s0.btot), .i_den(s0.tiles), .i_side(s0),
        .o_valid(v1), .i_ready(rd1), .o_quo(q1), .o_rem(r1), .o_side(n1)
    );

    always_comb begin
        s1     = n1;
        s1.per = q1 + 17'(r1 != '0);
    end

    atp_div #(.NW(17), .DW(17), .SW(SW)) u_div2 (
        .i_clk, .i_rst_n, .i_valid(v1), .o_ready(rd1),
        .i_num(s1.btot), .i_den(s1.per), .i_side(s1),
        .o_valid(v2), .i_ready(rd2), .o_quo(q2), .o_rem(r2), .o_side(n2)
    );

    logic [16:0] w_ngrp;
    always_comb begin
        s2     = n2;
        w_ngrp = q2 + 17'(r2 != '0);
    end

    atp_div #(.NW(13), .DW(13), .SW(SW)) u_div3 (
        .i_clk, .i_rst_n, .i_valid(v2), .o_ready(rd2),
        .i_num(s2.tiles), .i_den(w_ngrp[12:0]), .i_side(s2),
        .o_valid(v3), .i_ready(rd3), .o_quo(q3), .o_rem(r3), .o_side(n3)
    );

    always_comb begin
        s3     = n3;
        s3.run = q3;
    end

    atp_div #(.NW(16), .DW(17), .SW(SW)) u_div4 (
        .i_clk, .i_rst_n, .i_valid(v3), .o_ready(rd3),
        .i_num(s3.bidx), .i_den(s3.per), .i_side(s3),
        .o_valid(v4), .i_ready(rd4), .o_quo(q4), .o_rem(r4), .o_side(n4)
    );

    logic [25:0] w_first;
    always_comb begin
        s4      = n4;
        w_first = q4[12:0] * s4.run;
        if (s4.batched) begin
            s4.first = w_first[12:0];
            s4.cpge  = (s4.cpg == '0) ? CPG_W'(1) : s4.cpg;
            s4.zero  = (s4.cpg == '0);
        end else begin
            s4.first = '0;
            s4.run   = s4.tiles;
            s4.cpge  = CPG_W'(1);
            s4.zero  = 1'b0;
        end
    end

    atp_div #(.NW(32), .DW(16), .SW(SW)) u_div5 (
        .i_clk, .i_rst_n, .i_valid(v4), .o_ready(rd4),
        .i_num(s4.elems), .i_den(s4.cpge), .i_side(s4),
        .o_valid(v5), .i_ready(rd5), .o_quo(q5), .o_rem(r5), .o_side(n5)
    );

    always_comb begin
        s5        = n5;
        s5.groups = s5.zero ? '0 : q5;
        s5.zero   = s5.zero || (q5 == '0);
    end

    atp_div #(.NW(32), .DW(13), .SW(SW)) u_div6 (
        .i_clk, .i_rst_n, .i_valid(v5), .o_ready(rd5),
        .i_num(s5.groups), .i_den(s5.run), .i_side(s5),
        .o_valid(v6), .i_ready(rd6), .o_quo(q6), .o_rem(r6), .o_side(n6)
    );

    always_comb begin
        s6       = n6;
        w_maxper = q6 + 32'(r6 != '0);
        d7_den   = (w_maxper == '0) ? 32'd1 : w_maxper;
    end

    atp_div #(.NW(32), .DW(32), .SW(SW)) u_div7 (
        .i_clk, .i_rst_n, .i_valid(v6), .o_ready(rd6),
        .i_num(s6.groups), .i_den(d7_den), .i_side(s6),
        .o_valid(v7), .i_ready(rd7), .o_quo(q7), .o_rem(r7), .o_side(n7)
    );

    logic [47:0] w_total;
    always_comb begin
        s7       = n7;
        w_use    = 13'(q7 + 32'(r7 != '0));
        w_total  = s7.groups * s7.cpge;
        s7.total = w_total[31:0];
        w_end    = {1'b0, s7.first} + {1'b0, w_use};
        w_i      = '0;
        if (s7.tidx < s7.first) begin
            s7.region = REGION_LOW;
        end else if ({1'b0, s7.tidx} >= w_end) begin
            s7.region = REGION_HIGH;
        end else begin
            s7.region = REGION_MID;
            w_i       = s7.tidx - s7.first;
        end
        d8_num = 45'(w_i) * 45'(s7.groups);
        d8_den = (w_use == '0) ? 13'd1 : w_use;
    end

    atp_div #(.NW(45), .DW(13), .SW(SW)) u_div8 (
        .i_clk, .i_rst_n, .i_valid(v7), .o_ready(rd7),
        .i_num(d8_num), .i_den(d8_den), .i_side(s7),
        .o_valid(v8), .i_ready(rd8), .o_quo(q8), .o_rem(r8), .o_side(n8)
    );

    logic        r_ov;
    logic [31:0] r_off;
    logic        r_bad;
    logic [31:0] n_off;
    logic [47:0] w_mid;

    always_comb begin
        s8    = n8;
        w_mid = q8[31:0] * s8.cpge;
        n_off = '0;
        if (!s8.bad && !s8.zero) begin
            case (s8.region)
                REGION_HIGH: n_off = s8.total;
                REGION_MID:  n_off = w_mid[31:0];
                default:     n_off = '0;
            endcase
        end
    end

    assign rd_out = !r_ov || o_out.ready;
    assign rd8    = rd_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (rd_out) begin
            r_ov <= v8;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_out) begin
            r_off <= n_off;
            r_bad <= s8.bad;
        end
    end

    assign o_out.valid           = r_ov;
    assign o_out.boundary_offset = r_off;
    assign o_out.bad_request     = r_bad;
endmodule

>>> src/atp_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Uses assert_macros.svh.
`include "assert_macros.svh"
module atp_div #(
    parameter int unsigned NW = 32,
    parameter int unsigned DW = 16,
    parameter int unsigned SW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [NW-1:0] o_quo,
    output logic [DW-1:0] o_rem,
    output logic [SW-1:0] o_side
);
    logic [NW:0]   r_v;
    logic [NW-1:0] r_a    [0:NW];
    logic [DW-1:0] r_rem  [0:NW];
    logic [DW-1:0] r_den  [0:NW];
    logic [SW-1:0] r_side [0:NW];
    logic [NW+1:0] w_ld;

    assign w_ld[NW+1] = i_ready;

    genvar k;
    generate
        for (k = 0; k <= NW; k++) begin : g_ld
            assign w_ld[k] = !r_v[k] || w_ld[k+1];
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (w_ld[0]) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld[0]) begin
            r_a[0]    <= i_num;
            r_rem[0]  <= '0;
            r_den[0]  <= i_den;
            r_side[0] <= i_side;
        end
    end

    generate
        for (k = 1; k <= NW; k++) begin : g_stage
            logic [DW:0]   n_trial;
            logic [DW:0]   n_diff;
            logic          n_bit;
            logic [DW-1:0] n_rem;

            always_comb begin
                n_trial = {r_rem[k-1], r_a[k-1][NW-1]};
                n_diff  = n_trial - {1'b0, r_den[k-1]};
                n_bit   = n_trial >= {1'b0, r_den[k-1]};
                n_rem   = n_bit ? n_diff[DW-1:0] : n_trial[DW-1:0];
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else if (w_ld[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_ld[k]) begin
                    r_a[k]    <= {r_a[k-1][NW-2:0], n_bit};
                    r_rem[k]  <= n_rem;
                    r_den[k]  <= r_den[k-1];
                    r_side[k] <= r_side[k-1];
                end
            end
        end
    endgenerate

    assign o_ready = w_ld[0];
    assign o_valid = r_v[NW];
    assign o_quo   = r_a[NW];
    assign o_rem   = r_rem[NW];
    assign o_side  = r_side[NW];

    `ASSERT_NOW(a_rem_below_den, i_clk, i_rst_n, r_v[NW] && (r_den[NW] != '0),
        r_rem[NW] < r_den[NW], "remainder not below divisor")
    `ASSERT_NEXT(a_hold_on_stall, i_clk, i_rst_n, r_v[NW] && !i_ready,
        r_v[NW] && $stable(r_a[NW]) && $stable(r_side[NW]), "stalled result changed")
    `ASSERT_NEXT(a_no_loss, i_clk, i_rst_n, r_v[NW-1] && !w_ld[NW],
        r_v[NW-1] && $stable(r_a[NW-1]), "stage lost a transaction")
endmodule
